### design/lmwd_pkg.sv
package lmwd_pkg;

   localparam int PIX_W     = 8;
   localparam int COL_W     = 12;
   localparam int ROW_W     = 16;
   localparam int WIN_W     = 3;
   localparam int FW_W      = 13;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int COL_LIMIT = 4096;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;

   localparam logic [WIN_W-1:0] WINDOW_RESET = 3'd5;
   localparam logic [FW_W-1:0]  WIDTH_RESET  = 13'd4096;
   localparam logic [ROW_W-1:0] HEIGHT_RESET = 16'd4096;

   localparam logic [PIX_W-1:0] MARK_SET   = 8'd255;
   localparam logic [PIX_W-1:0] MARK_CLEAR = 8'd0;

   typedef logic [PIX_W-1:0] pixel_type;

   typedef struct packed {
      logic load;
      logic clear;
   } cell_ctl_type;

endpackage

### design/lmwd_cell.sv
module lmwd_cell import lmwd_pkg::*; #(
   parameter int DEPTH = 7
) (
   input  logic             clock,
   input  cell_ctl_type     ctl,
   input  pixel_type        shift_data [DEPTH],
   input  logic [WIN_W-1:0] lim,
   output pixel_type        col_out [DEPTH],
   output pixel_type        max_out
);

   pixel_type col_ff [DEPTH];
   pixel_type col_in [DEPTH];

   always_comb begin
      for (int a = 0; a < DEPTH; a++) begin
         col_in[a] = ctl.clear ? '0 : shift_data[a];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         col_ff <= col_in;
      end
   end

   // Maximum over the column, trimmed to the ages that fall inside the window.
   always_comb begin
      max_out = '0;
      for (int a = 0; a < DEPTH; a++) begin
         if (WIN_W'(a) <= lim && col_ff[a] > max_out) begin
            max_out = col_ff[a];
         end
      end
   end

   assign col_out = col_ff;

endmodule

### design/local_max_window_detector_core.sv
// Local maximum detector over a square window of 1 to 7 pixels on a raster
// frame of 8-bit pixels. A row of column cells holds the last window's worth
// of columns, fed from a line store of one row per window line, and a short
// pipeline takes the window maximum and compares the centre pixel against it.
// Away from the last column and row each request yields at most one result.
// One in the last column or row releases a burst of up to sixteen results,
// one per cycle unless the output stalls, and further requests wait while
// the burst drains. The line store needs no clearing.
module local_max_window_detector_core import lmwd_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_WINDOW = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PIX_W-1:0]     req_pixel,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [COL_W-1:0]     rsp_out_col,
   output logic [ROW_W-1:0]     rsp_out_row,
   output logic [PIX_W-1:0]     rsp_mark,
   output logic                 rsp_last_of_run,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   localparam int WIN       = (MAX_WINDOW < 7) ? MAX_WINDOW : 7;
   localparam int ROW_DEPTH = (MAX_WIDTH < COL_LIMIT) ? MAX_WIDTH : COL_LIMIT;
   localparam int ADDR_W    = $clog2(ROW_DEPTH);
   localparam int SLOT_W    = (WIN > 1) ? $clog2(WIN) : 1;

   logic [WIN_W-1:0]  win_ff;
   logic [FW_W-1:0]   fw_ff;
   logic [ROW_W-1:0]  fh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= WINDOW_RESET;
         fw_ff  <= WIDTH_RESET;
         fh_ff  <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WINDOW_SIZE:  win_ff <= csr_data[WIN_W-1:0];
            CSR_FRAME_WIDTH:  fw_ff  <= csr_data[FW_W-1:0];
            CSR_FRAME_HEIGHT: fh_ff  <= csr_data[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   logic [WIN_W-1:0] w_eff;
   logic [WIN_W-1:0] hi_w;
   logic [FW_W-1:0]  fw_eff;
   logic [ROW_W-1:0] fh_eff;
   logic [FW_W-1:0]  wmax;
   logic [ROW_W-1:0] hmax;

   always_comb begin
      if (win_ff == '0) begin
         w_eff = WIN_W'(1);
      end else if (win_ff > WIN_W'(WIN)) begin
         w_eff = WIN_W'(WIN);
      end else begin
         w_eff = win_ff;
      end
      if (fw_ff == '0) begin
         fw_eff = FW_W'(1);
      end else if (fw_ff > FW_W'(ROW_DEPTH)) begin
         fw_eff = FW_W'(ROW_DEPTH);
      end else begin
         fw_eff = fw_ff;
      end
      fh_eff = (fh_ff == '0) ? ROW_W'(1) : fh_ff;
   end

   assign hi_w = (w_eff - WIN_W'(1)) >> 1;
   assign wmax = fw_eff - FW_W'(1);
   assign hmax = fh_eff - ROW_W'(1);

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(WIN - 1)) ? '0 : s + SLOT_W'(1);
   endfunction

   // Position of the next pixel, normalized against the current frame size.
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [COL_W-1:0]  cur_x;
   logic [ROW_W-1:0]  cur_y;
   logic [SLOT_W-1:0] cur_s;
   logic              accept;

   always_comb begin
      logic              wrap_c;
      logic              wrap_r;
      logic [ROW_W:0]    yy;
      logic [SLOT_W-1:0] ys;
      logic [FW_W-1:0]   xn;
      logic [ROW_W:0]    yn;
      wrap_c = {1'b0, col_ff} >= fw_eff;
      yy     = wrap_c ? {1'b0, row_ff} + (ROW_W+1)'(1) : {1'b0, row_ff};
      ys     = wrap_c ? slot_inc(slot_ff) : slot_ff;
      wrap_r = yy >= {1'b0, fh_eff};
      cur_x  = wrap_c ? '0 : col_ff;
      cur_y  = wrap_r ? '0 : yy[ROW_W-1:0];
      cur_s  = wrap_r ? '0 : ys;
      xn     = {1'b0, cur_x} + FW_W'(1);
      yn     = {1'b0, cur_y} + (ROW_W+1)'(1);
      if (xn >= fw_eff) begin
         col_in = '0;
         if (yn >= {1'b0, fh_eff}) begin
            row_in  = '0;
            slot_in = '0;
         end else begin
            row_in  = yn[ROW_W-1:0];
            slot_in = slot_inc(cur_s);
         end
      end else begin
         col_in  = xn[COL_W-1:0];
         row_in  = cur_y;
         slot_in = cur_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   // Line store: one row memory per window line, row y kept in slot y mod WIN.
   pixel_type rd_ff [WIN];

   for (genvar s = 0; s < WIN; s++) begin : g_line
      pixel_type mem [ROW_DEPTH];
      always_ff @(posedge clock) begin
         if (accept) begin
            if (cur_s == SLOT_W'(s)) begin
               mem[cur_x[ADDR_W-1:0]] <= req_pixel;
            end
            rd_ff[s] <= mem[cur_x[ADDR_W-1:0]];
         end
      end
   end

   // Stage holding the accepted pixel while its column is read.
   logic              p_v_ff, p_v_in;
   pixel_type         p_pix_ff;
   logic [COL_W-1:0]  p_x_ff;
   logic [ROW_W-1:0]  p_y_ff;
   logic [SLOT_W-1:0] p_s_ff;
   logic              p_xlast_ff;
   logic              p_ylast_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         p_pix_ff   <= req_pixel;
         p_x_ff     <= cur_x;
         p_y_ff     <= cur_y;
         p_s_ff     <= cur_s;
         p_xlast_ff <= {1'b0, cur_x} == wmax;
         p_ylast_ff <= cur_y == hmax;
      end
   end

   pixel_type col_vec [WIN];

   always_comb begin
      int si;
      for (int a = 0; a < WIN; a++) begin
         si = int'(p_s_ff) - a;
         if (si < 0) begin
            si = si + WIN;
         end
         if (WIN_W'(a) >= w_eff || ROW_W'(a) > p_y_ff) begin
            col_vec[a] = '0;
         end else if (a == 0) begin
            col_vec[a] = p_pix_ff;
         end else begin
            col_vec[a] = rd_ff[SLOT_W'(si)];
         end
      end
   end

   // Sequencer over the results that one pixel releases.
   logic             seq_act_ff, seq_act_in;
   logic [WIN_W-1:0] seq_q_ff, seq_q_in;
   logic [WIN_W-1:0] seq_k_ff, seq_k_in;
   logic [WIN_W-1:0] seq_qs_ff, seq_qs_in;
   logic [WIN_W-1:0] seq_qe_ff, seq_qe_in;
   logic [WIN_W-1:0] seq_ke_ff, seq_ke_in;
   logic [COL_W-1:0] seq_x_ff, seq_x_in;
   logic [ROW_W-1:0] seq_y_ff, seq_y_in;
   logic             seq_end;
   logic             seq_free;
   logic             emit;
   logic             en_a;
   logic             en_o;
   cell_ctl_type     cell_ctl;

   assign seq_end  = (seq_q_ff == seq_qe_ff) && (seq_k_ff == seq_ke_ff);
   assign emit     = seq_act_ff && en_a;
   assign seq_free = !seq_act_ff || (en_a && seq_end);

   assign cell_ctl.load  = p_v_ff && seq_free;
   assign cell_ctl.clear = p_x_ff == '0;

   assign req_stall = p_v_ff && !seq_free;
   assign accept    = req_valid && !req_stall;
   assign p_v_in    = accept || (p_v_ff && !cell_ctl.load);

   always_comb begin
      logic qok;
      logic kok;
      logic [WIN_W-1:0] qs;
      logic [WIN_W-1:0] ks;
      qok = p_xlast_ff || (p_x_ff >= COL_W'(hi_w));
      kok = p_ylast_ff || (p_y_ff >= ROW_W'(hi_w));
      qs  = (p_xlast_ff && p_x_ff < COL_W'(hi_w)) ? hi_w - p_x_ff[WIN_W-1:0] : '0;
      ks  = (p_ylast_ff && p_y_ff < ROW_W'(hi_w)) ? hi_w - p_y_ff[WIN_W-1:0] : '0;
      seq_act_in = seq_act_ff;
      seq_q_in   = seq_q_ff;
      seq_k_in   = seq_k_ff;
      seq_qs_in  = seq_qs_ff;
      seq_qe_in  = seq_qe_ff;
      seq_ke_in  = seq_ke_ff;
      seq_x_in   = seq_x_ff;
      seq_y_in   = seq_y_ff;
      priority if (cell_ctl.load) begin
         seq_act_in = qok && kok;
         seq_q_in   = qs;
         seq_k_in   = ks;
         seq_qs_in  = qs;
         seq_qe_in  = p_xlast_ff ? hi_w : '0;
         seq_ke_in  = p_ylast_ff ? hi_w : '0;
         seq_x_in   = p_x_ff;
         seq_y_in   = p_y_ff;
      end else if (emit) begin
         if (seq_end) begin
            seq_act_in = 1'b0;
         end else if (seq_q_ff == seq_qe_ff) begin
            seq_q_in = seq_qs_ff;
            seq_k_in = seq_k_ff + WIN_W'(1);
         end else begin
            seq_q_in = seq_q_ff + WIN_W'(1);
         end
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_act_ff <= 1'b0;
         p_v_ff     <= 1'b0;
      end else begin
         seq_act_ff <= seq_act_in;
         p_v_ff     <= p_v_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_q_ff  <= seq_q_in;
      seq_k_ff  <= seq_k_in;
      seq_qs_ff <= seq_qs_in;
      seq_qe_ff <= seq_qe_in;
      seq_ke_ff <= seq_ke_in;
      seq_x_ff  <= seq_x_in;
      seq_y_ff  <= seq_y_in;
   end

   // Row of column cells; cell d holds column x - d of the current pixel.
   pixel_type        cell_col [WIN][WIN];
   pixel_type        cell_max [WIN];
   logic [WIN_W-1:0] row_lim;
   cell_ctl_type     head_ctl;

   assign row_lim = w_eff - WIN_W'(1) - seq_k_ff;

   // The head cell always takes the new column; only older columns are cleared.
   assign head_ctl.load  = cell_ctl.load;
   assign head_ctl.clear = 1'b0;

   for (genvar d = 0; d < WIN; d++) begin : g_cell
      if (d == 0) begin : g_head
         lmwd_cell #(.DEPTH(WIN)) u_cell (
            .clock      (clock),
            .ctl        (head_ctl),
            .shift_data (col_vec),
            .lim        (row_lim),
            .col_out    (cell_col[d]),
            .max_out    (cell_max[d])
         );
      end else begin : g_body
         lmwd_cell #(.DEPTH(WIN)) u_cell (
            .clock      (clock),
            .ctl        (cell_ctl),
            .shift_data (cell_col[d-1]),
            .lim        (row_lim),
            .col_out    (cell_col[d]),
            .max_out    (cell_max[d])
         );
      end
   end

   // Stage A: trimmed column maxima and the centre pixel.
   logic             a_v_ff, a_v_in;
   pixel_type        a_cm_ff [WIN];
   pixel_type        a_cen_ff;
   logic [WIN_W-1:0] a_lim_ff;
   logic [COL_W-1:0] a_col_ff;
   logic [ROW_W-1:0] a_row_ff;
   logic             a_last_ff;
   logic [WIN_W-1:0] cen_d;
   logic [WIN_W-1:0] cen_a;

   assign cen_d  = hi_w - seq_q_ff;
   assign cen_a  = hi_w - seq_k_ff;
   assign en_o   = !rsp_valid || !rsp_stall;
   assign en_a   = !a_v_ff || en_o;
   assign a_v_in = en_a ? emit : a_v_ff;

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_cm_ff   <= cell_max;
         a_cen_ff  <= cell_col[cen_d[SLOT_W-1:0]][cen_a[SLOT_W-1:0]];
         a_lim_ff  <= w_eff - WIN_W'(1) - seq_q_ff;
         a_col_ff  <= seq_x_ff - COL_W'(hi_w) + COL_W'(seq_q_ff);
         a_row_ff  <= seq_y_ff - ROW_W'(hi_w) + ROW_W'(seq_k_ff);
         a_last_ff <= seq_end;
      end
   end

   // Output stage: window maximum across the cells and the comparison.
   logic             o_v_ff;
   logic [COL_W-1:0] o_col_ff;
   logic [ROW_W-1:0] o_row_ff;
   pixel_type        o_mark_ff;
   logic             o_last_ff;
   pixel_type        win_max;

   always_comb begin
      win_max = '0;
      for (int d = 0; d < WIN; d++) begin
         if (WIN_W'(d) <= a_lim_ff && a_cm_ff[d] > win_max) begin
            win_max = a_cm_ff[d];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         a_v_ff <= a_v_in;
         if (en_o) begin
            o_v_ff <= a_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_o) begin
         o_col_ff  <= a_col_ff;
         o_row_ff  <= a_row_ff;
         o_mark_ff <= (a_cen_ff == win_max) ? MARK_SET : MARK_CLEAR;
         o_last_ff <= a_last_ff;
      end
   end

   assign rsp_valid       = o_v_ff;
   assign rsp_out_col     = o_col_ff;
   assign rsp_out_row     = o_row_ff;
   assign rsp_mark        = o_mark_ff;
   assign rsp_last_of_run = o_last_ff;

`ifndef SYNTHESIS
   a_seq_range: assert property (@(posedge clock) disable iff (reset)
      seq_act_ff |-> (seq_q_ff <= hi_w && seq_k_ff <= hi_w))
      else $error("sequencer index beyond window half size");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> p_v_ff)
      else $error("accepted request did not reach the column stage");

   a_hold_pixel: assert property (@(posedge clock) disable iff (reset)
      (p_v_ff && !seq_free) |=> (p_v_ff && $stable(p_x_ff) && $stable(p_y_ff)))
      else $error("waiting pixel lost while a burst drains");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      (seq_act_ff && !seq_end) |-> !cell_ctl.load)
      else $error("cells shifted in the middle of a burst");
`endif

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
   import lmwd_pkg::*;

   localparam int STORE_ROWS = 7;
   localparam int STORE_COLS = 4096;

   typedef struct {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [PIX_W-1:0] mark;
      logic             last;
   } mark_result_t;

   class max_mark_board;
      logic [PIX_W-1:0] line_store [STORE_ROWS*STORE_COLS];
      int unsigned col_pos, row_pos;
      logic [WIN_W-1:0] win_reg;
      logic [FW_W-1:0]  width_reg;
      logic [ROW_W-1:0] height_reg;
      mark_result_t pending_marks[$];
      int errors;

      function void clear_state();
         col_pos = 0;
         row_pos = 0;
         win_reg = WINDOW_RESET;
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
         case (idx)
            CSR_WINDOW_SIZE: begin
               win_reg = value[WIN_W-1:0];
            end
            CSR_FRAME_WIDTH: begin
               width_reg = value[FW_W-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               height_reg = value[ROW_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function logic [PIX_W-1:0] read_store(int c, int r, int wmax, int hmax);
         if (c < 0) c = 0;
         if (c > wmax) c = wmax;
         if (r < 0) r = 0;
         if (r > hmax) r = hmax;
         return line_store[(r % STORE_ROWS) * STORE_COLS + c];
      endfunction

      function void note_pixel(logic [PIX_W-1:0] pix);
         int unsigned win, fw, fh;
         int lo, hi, x, y, wmax, hmax, r0, r1, c0, c1, n;
         logic [PIX_W-1:0] peak, centre, v;
         mark_result_t res;
         win = (win_reg == 0) ? 1 : win_reg;
         fw = (width_reg == 0) ? 1 : width_reg;
         if (fw > STORE_COLS) fw = STORE_COLS;
         fh = (height_reg == 0) ? 1 : height_reg;
         lo = -int'(win / 2);
         hi = int'(win) - 1 - int'(win / 2);
         if (col_pos >= fw) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos >= fh) row_pos = 0;
         x = col_pos;
         y = row_pos;
         wmax = fw - 1;
         hmax = fh - 1;
         line_store[(y % STORE_ROWS) * STORE_COLS + x] = pix;
         r0 = y - hi;
         r1 = (y == hmax) ? y : r0;
         if (y == hmax && r0 < 0) r0 = 0;
         c0 = x - hi;
         c1 = (x == wmax) ? x : c0;
         if (x == wmax && c0 < 0) c0 = 0;
         n = 0;
         if (r0 >= 0 && c0 >= 0) begin
            for (int r = r0; r <= r1; r++) begin
               for (int c = c0; c <= c1; c++) begin
                  peak = 0;
                  centre = read_store(c, r, wmax, hmax);
                  for (int dy = lo; dy <= hi; dy++) begin
                     for (int dx = lo; dx <= hi; dx++) begin
                        v = read_store(c + dx, r + dy, wmax, hmax);
                        if (v > peak) peak = v;
                     end
                  end
                  res.col = COL_W'(c);
                  res.row = ROW_W'(r);
                  res.mark = (centre == peak) ? MARK_SET : MARK_CLEAR;
                  res.last = 1'b0;
                  pending_marks.push_back(res);
                  n++;
               end
            end
            if (n > 0) pending_marks[pending_marks.size()-1].last = 1'b1;
         end
         col_pos++;
         if (col_pos >= fw) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= fh) row_pos = 0;
         end
      endfunction

      task report(string what);
         $display("ERROR at %0t: %s", $time, what);
         errors++;
      endtask

      task check_mark(logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                      logic [PIX_W-1:0] mark, logic last);
         mark_result_t want;
         if (pending_marks.size() == 0) begin
            report($sformatf("unexpected result col %0d row %0d", col, row));
            return;
         end
         want = pending_marks.pop_front();
         if (col !== want.col)
            report($sformatf("out_col %0d, expected %0d", col, want.col));
         if (row !== want.row)
            report($sformatf("out_row %0d, expected %0d", row, want.row));
         if (mark !== want.mark)
            report($sformatf("mark %0d, expected %0d at col %0d row %0d",
                             mark, want.mark, want.col, want.row));
         if (last !== want.last)
            report($sformatf("last_of_run %0d, expected %0d", last, want.last));
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [PIX_W-1:0]     req_pixel;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [COL_W-1:0]     rsp_out_col;
   logic [ROW_W-1:0]     rsp_out_row;
   logic [PIX_W-1:0]     rsp_mark;
   logic                 rsp_last_of_run;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_data;

   max_mark_board board;
   bit hold_output;
   bit hold_active;
   int pixels_sent;

   local_max_window_detector_core DUT (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #50ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) board.note_pixel(req_pixel);
      if (!reset && rsp_valid && !rsp_stall)
         board.check_mark(rsp_out_col, rsp_out_row, rsp_mark, rsp_last_of_run);
   end

   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) return 0;
      if (sel < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   initial begin
      int gap;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_output) begin
            hold_active = 1'b1;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            hold_output = 1'b0;
            hold_active = 1'b0;
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            rsp_stall <= (gap > 0);
            repeat ((gap > 0) ? gap : $urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      board.set_reg(idx, value);
   endtask

   task automatic send_pixel(logic [PIX_W-1:0] pix, bit with_gaps);
      int gap;
      req_valid <= 1'b1;
      req_pixel <= pix;
      do @(posedge clock); while (!(req_valid && !req_stall));
      gap = with_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_pixel <= PIX_W'($urandom_range(0, 255));
         repeat (gap) @(posedge clock);
      end
      pixels_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending_marks.size() != 0 || hold_active) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic run_frames(logic [CSR_W-1:0] win, logic [CSR_W-1:0] fw,
                             logic [CSR_W-1:0] fh, int frames, bit with_gaps);
      int unsigned w, h, style, base;
      logic [PIX_W-1:0] pix;
      write_reg(CSR_WINDOW_SIZE, win);
      write_reg(CSR_FRAME_WIDTH, fw);
      write_reg(CSR_FRAME_HEIGHT, fh);
      w = (fw[FW_W-1:0] == 0) ? 1 : fw[FW_W-1:0];
      if (w > STORE_COLS) w = STORE_COLS;
      h = (fh == 0) ? 1 : fh;
      for (int f = 0; f < frames; f++) begin
         style = $urandom_range(0, 3);
         base = $urandom_range(0, 255);
         for (int i = 0; i < w * h; i++) begin
            case (style)
               0: pix = PIX_W'($urandom_range(0, 255));
               1: pix = PIX_W'(base);
               2: pix = PIX_W'($urandom_range(0, 2) * 127);
               default: pix = PIX_W'(base ^ $urandom_range(0, 3));
            endcase
            send_pixel(pix, with_gaps);
         end
      end
      drain();
   endtask

   initial begin
      board = new();
      board.clear_state();
      hold_output = 1'b0;
      hold_active = 1'b0;
      pixels_sent = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel = '0;
      csr_write = 1'b0;
      csr_index = CSR_WINDOW_SIZE;
      csr_data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_frames(0, 0, 0, 2, 1'b1);
      run_frames(7, 3, 3, 1, 1'b1);
      run_frames(1, 4, 2, 1, 1'b0);
      run_frames(2, 2, 3, 1, 1'b1);
      while (pixels_sent < 130) begin
         run_frames(CSR_W'($urandom_range(0, 7)), CSR_W'($urandom_range(1, 14)),
                    CSR_W'($urandom_range(1, 8)), 1, $urandom_range(0, 4) != 0);
      end
      hold_output = 1'b1;
      run_frames(5, 16, 8, 1, 1'b0);
      run_frames(5, 6, 5, 1, 1'b1);

      if (board.errors == 0 && board.pending_marks.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
